[src/toq_pkg.sv]
// ----------------------------------------------------------------------------
// toq_pkg
// Shared types and codes for the time-ordered event queue.
// ----------------------------------------------------------------------------
package toq_pkg;

    // Operation codes carried by an input item.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Status codes reported with every result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One stored event.
    typedef struct packed {
        logic [7:0]  etype;
        logic [31:0] etime;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
    } dp_status_t;

endpackage

[src/toq_in_if.sv]
// ----------------------------------------------------------------------------
// toq_in_if
// Input channel: one operation item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface toq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  event_type;
    logic [31:0] event_time;

    modport source (output valid, output operation, output event_type,
                    output event_time, input ready);
    modport sink   (input valid, input operation, input event_type,
                    input event_time, output ready);
endinterface

[src/toq_out_if.sv]
// ----------------------------------------------------------------------------
// toq_out_if
// Output channel: one result item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface toq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        queue_empty;
    logic [7:0]  head_type;
    logic [31:0] head_time;
    logic [4:0]  occupancy;

    modport source (output valid, output status, output queue_empty,
                    output head_type, output head_time, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input queue_empty,
                    input head_type, input head_time, input occupancy,
                    output ready);
endinterface

[src/time_ordered_event_queue_core.sv]
// ----------------------------------------------------------------------------
// time_ordered_event_queue_core
// Event queue kept sorted by time, with insert, pop and clear operations.
// ----------------------------------------------------------------------------
// The cell row updates at the edge that accepts an item; the result register
// loads in the cycle after. A new item is taken once that result is loaded and
// the output slot is free or being emptied. The QUEUE_DEPTH compare-and-shift
// cells place an insert or pop at the edge that accepts it; equal times keep
// arrival order. There is no clearing pass after reset.
module time_ordered_event_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    toq_in_if.sink           cmd,
    toq_out_if.source        rsp
);
    import toq_pkg::*;

    ctrl_cmd_t  ctl;
    dp_status_t dp_stat;

    toq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .operation (cmd.operation),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (rsp.status),
        .cmd       (ctl),
        .dp_stat   (dp_stat)
    );

    toq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl),
        .operation   (cmd.operation),
        .event_type  (cmd.event_type),
        .event_time  (cmd.event_time),
        .dp_stat     (dp_stat),
        .queue_empty (rsp.queue_empty),
        .head_type   (rsp.head_type),
        .head_time   (rsp.head_time),
        .occupancy   (rsp.occupancy)
    );

endmodule

[src/toq_ctrl.sv]
// ----------------------------------------------------------------------------
// toq_ctrl
// Controller: sequences accept and result load, owns the handshakes and
// the status code of each result item.
// ----------------------------------------------------------------------------
module toq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output toq_pkg::ctrl_cmd_t  cmd,
    input  toq_pkg::dp_status_t dp_stat
);
    import toq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RESULT
    } state_t;

    state_t     state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic       accept;

    // An item is taken only when the output slot is free or being emptied.
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign cmd.accept = accept;
    assign cmd.load   = (state_reg == S_RESULT);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;

    // Next state, result flag and status code.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESULT;
                    if (operation == OP_INSERT && dp_stat.full)
                    begin
                        status_next = ST_FULL;
                    end
                    else if (operation == OP_POP && dp_stat.empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        status_next = ST_OK;
                    end
                end
            end
            S_RESULT:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

endmodule

[src/toq_datapath.sv]
// ----------------------------------------------------------------------------
// toq_datapath
// Sorted row of compare-and-shift cells, occupancy tracking and the
// result payload register.
// ----------------------------------------------------------------------------
module toq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  toq_pkg::ctrl_cmd_t  cmd,
    input  logic [1:0]          operation,
    input  logic [7:0]          event_type,
    input  logic [31:0]         event_time,
    output toq_pkg::dp_status_t dp_stat,
    output logic                queue_empty,
    output logic [7:0]          head_type,
    output logic [31:0]         head_time,
    output logic [4:0]          occupancy
);
    import toq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t                 cell_reg [QUEUE_DEPTH];
    entry_t                 cell_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occ_reg, occ_next;
    logic [QUEUE_DEPTH-1:0] le;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_insert, do_pop, do_clear;
    entry_t                 new_entry;
    logic                   empty_res_reg;
    logic [7:0]             head_type_reg;
    logic [31:0]            head_time_reg;
    logic [4:0]             occupancy_reg;

    assign dp_stat.full  = occ_reg[QUEUE_DEPTH-1];
    assign dp_stat.empty = !occ_reg[0];

    assign do_insert = cmd.accept && operation == OP_INSERT && !dp_stat.full;
    assign do_pop    = cmd.accept && operation == OP_POP && !dp_stat.empty;
    assign do_clear  = cmd.accept && operation == OP_CLEAR;

    assign new_entry.etype = event_type;
    assign new_entry.etime = event_time;

    // Each cell keeps, takes the new event, or shifts in from a neighbor.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        assign le[i] = occ_reg[i] && (cell_reg[i].etime <= event_time);

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            occ_next[i]  = occ_reg[i];
            if (do_insert)
            begin
                if (i == 0)
                begin
                    occ_next[i] = 1'b1;
                    if (!le[i])
                    begin
                        cell_next[i] = new_entry;
                    end
                end
                else
                begin
                    occ_next[i] = occ_reg[i] | occ_reg[(i > 0) ? i - 1 : 0];
                    if (!le[i])
                    begin
                        cell_next[i] = le[(i > 0) ? i - 1 : 0] ? new_entry
                                                               : cell_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            else if (do_pop)
            begin
                if (i == QUEUE_DEPTH - 1)
                begin
                    occ_next[i] = 1'b0;
                end
                else
                begin
                    occ_next[i]  = occ_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                    cell_next[i] = cell_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                end
            end
            else if (do_clear)
            begin
                occ_next[i] = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Event count follows the occupied cells.
    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (do_clear)
        begin
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            occ_reg   <= occ_next;
            count_reg <= count_next;
        end
    end

    // Result payload is captured from the updated cells.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            empty_res_reg <= !occ_reg[0];
            head_type_reg <= occ_reg[0] ? cell_reg[0].etype : 8'd0;
            head_time_reg <= occ_reg[0] ? cell_reg[0].etime : 32'd0;
            occupancy_reg <= 5'(count_reg);
        end
    end

    assign queue_empty = empty_res_reg;
    assign head_type   = head_type_reg;
    assign head_time   = head_time_reg;
    assign occupancy   = occupancy_reg;

endmodule

[src/toq_checker.sv]
// ----------------------------------------------------------------------------
// toq_checker
// Port-level checks on the event queue, bound to the top level.
// ----------------------------------------------------------------------------
module toq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        queue_empty,
    input logic [7:0]  head_type,
    input logic [31:0] head_time,
    input logic [4:0]  occupancy
);
    import toq_pkg::*;

    // A result is flagged after each accepted item, once the result state has loaded it.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 out_valid)
        else $error("no result after accepted item");

    // The block works on one item at a time.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous one in flight");

    // A dropped insert means the queue holds events.
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> !queue_empty && occupancy != 5'd0)
        else $error("full status on an empty queue");

    // An empty queue reports a zero head.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && queue_empty |-> head_type == 8'd0 && head_time == 32'd0)
        else $error("empty queue with nonzero head");

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(head_time) && $stable(occupancy))
        else $error("stalled result changed");

endmodule

bind time_ordered_event_queue_core toq_checker u_toq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (cmd.valid),
    .in_ready    (cmd.ready),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .status      (rsp.status),
    .queue_empty (rsp.queue_empty),
    .head_type   (rsp.head_type),
    .head_time   (rsp.head_time),
    .occupancy   (rsp.occupancy)
);
